[rtl/bmpdec_pkg.sv]
// Shared types, constants and helpers for the BMP stream pixel decoder.
`timescale 1ns / 1ps

package bmpdec_pkg;

  // Largest accepted width or height magnitude.
  localparam int MAX_DIM = 4096;

  // Header layout.
  localparam int HDR_LEN    = 54;
  localparam int OFF_DATA   = 10;
  localparam int OFF_WIDTH  = 18;
  localparam int OFF_HEIGHT = 22;
  localparam int OFF_BPP    = 28;
  localparam int OFF_COMP   = 30;
  localparam int BPP_24     = 24;
  localparam int BPP_32     = 32;

  localparam logic [7:0] SIG_B        = 8'h42;
  localparam logic [7:0] SIG_M        = 8'h4D;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Result queue between the parser and the output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SIG   = 2'd0,
    ERR_FMT   = 2'd1,
    ERR_TRUNC = 2'd2
  } err_t;

  // One queued result. For a pixel the width field carries the image width
  // so the output stage can form the destination index.
  typedef struct packed {
    kind_t       kind;
    logic [12:0] width;
    logic [12:0] height;
    logic [23:0] rgb;
    logic [11:0] x;
    logic [11:0] y;
    err_t        err;
    logic        last;
  } res_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic res_t mk_res(kind_t k);
    res_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic res_t mk_err(err_t e);
    res_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.err  = e;
    return r;
  endfunction

endpackage

[rtl/bmpdec_if.sv]
// Channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface bmpdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface bmpdec_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [31:0] pixel_argb;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [23:0] pixel_index;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output kind, output image_width, output image_height,
                  output pixel_argb, output pixel_x, output pixel_y, output pixel_index,
                  output error_code, output last_of_run, input ready);
  modport sink (input valid, input kind, input image_width, input image_height,
                input pixel_argb, input pixel_x, input pixel_y, input pixel_index,
                input error_code, input last_of_run, output ready);
endinterface

[rtl/bmpdec_front.sv]
// Byte parser: header capture and checks, offset skip, row and pixel assembly.
`timescale 1ns / 1ps

module bmpdec_front import bmpdec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output push_t      push
);

  phase_t      phase_r, phase_nxt, ph;
  logic [31:0] pos_r, pos_nxt, pos_cur;
  logic [5:0]  hp;

  // Raw header fields.
  logic [7:0]  sig0_r, sig0_nxt, sig1_r, sig1_nxt;
  logic [31:0] off_r, off_nxt, wid_r, wid_nxt, hgt_r, hgt_nxt, comp_r, comp_nxt;
  logic [15:0] bpp_r, bpp_nxt;

  // Image geometry and row walking state.
  logic [31:0] data_start_r, data_start_nxt;
  logic [12:0] width_r, width_nxt, height_r, height_nxt;
  logic        flip_r, flip_nxt, four_r, four_nxt;
  logic [14:0] data_bytes_r, data_bytes_nxt, row_last_r, row_last_nxt;
  logic [14:0] row_byte_r, row_byte_nxt;
  logic [11:0] col_r, col_nxt, row_r, row_nxt;
  logic [1:0]  pbp_r, pbp_nxt;
  logic [7:0]  blue_r, blue_nxt, green_r, green_nxt;

  // Header check terms.
  logic [31:0] hmag;
  logic        fmt_bad;
  logic [14:0] db, db_p3, rsize;

  // Pixel terms.
  logic [12:0] y13, row_inc13;
  logic        row_end, done, pix;
  logic [1:0]  pbp_last;

  res_t        rq [2];
  logic [1:0]  n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sig0_r       <= sig0_nxt;
    sig1_r       <= sig1_nxt;
    off_r        <= off_nxt;
    wid_r        <= wid_nxt;
    hgt_r        <= hgt_nxt;
    comp_r       <= comp_nxt;
    bpp_r        <= bpp_nxt;
    data_start_r <= data_start_nxt;
    width_r      <= width_nxt;
    height_r     <= height_nxt;
    flip_r       <= flip_nxt;
    four_r       <= four_nxt;
    data_bytes_r <= data_bytes_nxt;
    row_last_r   <= row_last_nxt;
    row_byte_r   <= row_byte_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    pbp_r        <= pbp_nxt;
    blue_r       <= blue_nxt;
    green_r      <= green_nxt;
  end

  // Header checks read only captured fields; the last header byte carries none.
  always_comb begin
    hmag    = hgt_r[31] ? (32'd0 - hgt_r) : hgt_r;
    fmt_bad = (comp_r != 32'd0) ||
              ((bpp_r != 16'(BPP_24)) && (bpp_r != 16'(BPP_32))) ||
              wid_r[31] || (wid_r > 32'(MAX_DIM)) || (hmag > 32'(MAX_DIM)) ||
              (off_r < 32'(HDR_LEN));
    if (bpp_r == 16'(BPP_32)) begin
      db = {wid_r[12:0], 2'b00};
    end else begin
      db = {1'b0, wid_r[12:0], 1'b0} + {2'b00, wid_r[12:0]};
    end
    db_p3 = db + 15'd3;
    rsize = {db_p3[14:2], 2'b00};
  end

  always_comb begin
    y13       = flip_r ? (height_r - 13'd1 - {1'b0, row_r}) : {1'b0, row_r};
    row_inc13 = {1'b0, row_r} + 13'd1;
    row_end   = (row_byte_r == row_last_r);
    done      = row_end && (row_inc13 >= height_r);
    pbp_last  = four_r ? 2'd3 : 2'd2;
  end

  always_comb begin
    ph             = first_byte ? PH_HEADER : phase_r;
    pos_cur        = first_byte ? 32'd0 : pos_r;
    hp             = pos_cur[5:0];
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    sig0_nxt       = sig0_r;
    sig1_nxt       = sig1_r;
    off_nxt        = off_r;
    wid_nxt        = wid_r;
    hgt_nxt        = hgt_r;
    comp_nxt       = comp_r;
    bpp_nxt        = bpp_r;
    data_start_nxt = data_start_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    flip_nxt       = flip_r;
    four_nxt       = four_r;
    data_bytes_nxt = data_bytes_r;
    row_last_nxt   = row_last_r;
    row_byte_nxt   = row_byte_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    pbp_nxt        = pbp_r;
    blue_nxt       = blue_r;
    green_nxt      = green_r;
    pix            = 1'b0;
    rq[0]          = '0;
    rq[1]          = '0;
    n              = 2'd0;

    if (accept) begin
      phase_nxt = ph;
      pos_nxt   = pos_cur;
      unique case (ph)
        PH_HEADER: begin
          if (pos_cur != 32'(HDR_LEN - 1)) begin
            pos_nxt = pos_cur + 32'd1;
            if (hp == 6'd0) sig0_nxt = data_byte;
            if (hp == 6'd1) sig1_nxt = data_byte;
            for (int i = 0; i < 4; i++) begin
              if (hp == 6'(OFF_DATA + i))   off_nxt[i*8 +: 8]  = data_byte;
              if (hp == 6'(OFF_WIDTH + i))  wid_nxt[i*8 +: 8]  = data_byte;
              if (hp == 6'(OFF_HEIGHT + i)) hgt_nxt[i*8 +: 8]  = data_byte;
              if (hp == 6'(OFF_COMP + i))   comp_nxt[i*8 +: 8] = data_byte;
            end
            for (int i = 0; i < 2; i++) begin
              if (hp == 6'(OFF_BPP + i)) bpp_nxt[i*8 +: 8] = data_byte;
            end
            if (last_byte) begin
              rq[0]     = mk_err(ERR_TRUNC);
              n         = 2'd1;
              phase_nxt = PH_DONE;
            end
          end else if ((sig0_r != SIG_B) || (sig1_r != SIG_M)) begin
            rq[0]     = mk_err(ERR_SIG);
            n         = 2'd1;
            phase_nxt = PH_DONE;
          end else if (fmt_bad) begin
            rq[0]     = mk_err(ERR_FMT);
            n         = 2'd1;
            phase_nxt = PH_DONE;
          end else begin
            data_start_nxt = off_r;
            width_nxt      = wid_r[12:0];
            height_nxt     = hmag[12:0];
            flip_nxt       = !hgt_r[31] && (hgt_r != 32'd0);
            four_nxt       = (bpp_r == 16'(BPP_32));
            data_bytes_nxt = db;
            row_last_nxt   = rsize - 15'd1;
            row_byte_nxt   = '0;
            col_nxt        = '0;
            row_nxt        = '0;
            pbp_nxt        = '0;
            pos_nxt        = 32'(HDR_LEN);
            rq[0]          = mk_res(KIND_HEADER);
            rq[0].width    = wid_r[12:0];
            rq[0].height   = hmag[12:0];
            n              = 2'd1;
            if ((wid_r[12:0] == 13'd0) || (hmag[12:0] == 13'd0)) begin
              rq[1]     = mk_res(KIND_DONE);
              n         = 2'd2;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = (off_r == 32'(HDR_LEN)) ? PH_PIXELS : PH_SKIP;
              if (last_byte) begin
                rq[1]     = mk_err(ERR_TRUNC);
                n         = 2'd2;
                phase_nxt = PH_DONE;
              end
            end
          end
        end

        PH_SKIP: begin
          if (pos_cur == data_start_r - 32'd1) phase_nxt = PH_PIXELS;
          pos_nxt = pos_cur + 32'd1;
          if (last_byte) begin
            rq[0]     = mk_err(ERR_TRUNC);
            n         = 2'd1;
            phase_nxt = PH_DONE;
          end
        end

        PH_PIXELS: begin
          if (row_byte_r < data_bytes_r) begin
            if (pbp_r == 2'd0) blue_nxt = data_byte;
            if (pbp_r == 2'd1) green_nxt = data_byte;
            if (pbp_r == 2'd2) begin
              pix     = 1'b1;
              col_nxt = col_r + 12'd1;
            end
            pbp_nxt = (pbp_r == pbp_last) ? 2'd0 : (pbp_r + 2'd1);
          end
          if (row_end) begin
            row_byte_nxt = '0;
            col_nxt      = '0;
            pbp_nxt      = '0;
            row_nxt      = row_inc13[11:0];
          end else begin
            row_byte_nxt = row_byte_r + 15'd1;
          end
          // A pixel finished on a truncating byte is dropped.
          if (pix && (done || !last_byte)) begin
            rq[0]       = mk_res(KIND_PIXEL);
            rq[0].rgb   = {data_byte, green_r, blue_r};
            rq[0].x     = col_r;
            rq[0].y     = y13[11:0];
            rq[0].width = width_r;
            n           = 2'd1;
          end
          if (done) begin
            rq[n[0]]  = mk_res(KIND_DONE);
            n         = n + 2'd1;
            phase_nxt = PH_DONE;
          end else if (last_byte) begin
            rq[n[0]]  = mk_err(ERR_TRUNC);
            n         = n + 2'd1;
            phase_nxt = PH_DONE;
          end
        end

        PH_IDLE, PH_DONE: begin
        end

        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (n == 2'd2) begin
      rq[1].last = 1'b1;
    end else if (n == 2'd1) begin
      rq[0].last = 1'b1;
    end
    push.count = n;
    push.res0  = rq[0];
    push.res1  = rq[1];
  end

endmodule

[rtl/bmpdec_queue.sv]
// Short result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module bmpdec_queue import bmpdec_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  room,
  output logic  head_valid,
  output res_t  head
);

  res_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign wr_ptr_p1  = wr_ptr_r + Q_PTR_W'(1);
  assign room       = (count_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr_r] <= push.res0;
    if (push.count == 2'd2) mem[wr_ptr_p1] <= push.res1;
  end

endmodule

[rtl/bmpdec_back.sv]
// Output register stage: forms ARGB and the destination index, holds under stall.
`timescale 1ns / 1ps

module bmpdec_back import bmpdec_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  res_t         head,
  output logic         pop,
  bmpdec_out_if.source out_bus
);

  logic        valid_r, valid_nxt, load;
  kind_t       kind_r;
  logic [12:0] width_r, height_r;
  logic [31:0] argb_r;
  logic [11:0] x_r, y_r;
  logic [23:0] index_r;
  err_t        err_r;
  logic        last_r;
  logic        is_pix, is_hdr;
  logic [24:0] prod, sum;

  assign load      = !valid_r || out_bus.ready;
  assign pop       = head_valid && load;
  assign valid_nxt = load ? head_valid : valid_r;
  assign is_pix    = (head.kind == KIND_PIXEL);
  assign is_hdr    = (head.kind == KIND_HEADER);
  assign prod      = 25'(head.y) * 25'(head.width);
  assign sum       = prod + 25'(head.x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= head.kind;
      width_r  <= is_hdr ? head.width : 13'd0;
      height_r <= is_hdr ? head.height : 13'd0;
      argb_r   <= is_pix ? {ALPHA_OPAQUE, head.rgb} : 32'd0;
      x_r      <= is_pix ? head.x : 12'd0;
      y_r      <= is_pix ? head.y : 12'd0;
      index_r  <= is_pix ? sum[23:0] : 24'd0;
      err_r    <= head.err;
      last_r   <= head.last;
    end
  end

  assign out_bus.valid        = valid_r;
  assign out_bus.kind         = kind_r;
  assign out_bus.image_width  = width_r;
  assign out_bus.image_height = height_r;
  assign out_bus.pixel_argb   = argb_r;
  assign out_bus.pixel_x      = x_r;
  assign out_bus.pixel_y      = y_r;
  assign out_bus.pixel_index  = index_r;
  assign out_bus.error_code   = err_r;
  assign out_bus.last_of_run  = last_r;

endmodule

[rtl/bmp_stream_pixel_decoder.sv]
// Top level of the BMP stream pixel decoder (24- and 32-bit uncompressed).
// The in_bus channel takes one file byte per request; first_byte restarts the
// parser on a new file and last_byte marks the end of the stream. A request is
// taken when valid and ready are both high at a rising clock edge.
// The out_bus channel returns results: header accepted, pixel, image complete
// or error. One byte causes at most two results; last_of_run marks the last.
// The results of a taken byte are queued, then registered onto out_bus in order.
// Throughput: one byte per clock while in_bus.ready is high. A four-entry
// result queue sits between the parser and the output register; in_bus.ready
// drops only while fewer than two queue entries are free. A byte adds at most
// two entries and the output register drains one per clock, so the queue only
// fills while out_bus stalls. A stalled out_bus holds its result steady; bytes
// keep flowing until the queue fills. Reset (rst_n low, synchronous) empties
// the queue and the output register and puts the parser in idle, where it
// waits for a first_byte.
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder import bmpdec_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bmpdec_in_if.sink    in_bus,
  bmpdec_out_if.source out_bus
);

  push_t push;
  logic  room;
  logic  head_valid;
  res_t  head;
  logic  pop;
  logic  accept;

  // Ready depends only on queue occupancy, never on the parser phase.
  assign in_bus.ready = room;
  assign accept       = in_bus.valid && room;

  // Front part: parses each taken byte and produces zero, one or two results.
  bmpdec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_bus.data_byte),
    .first_byte (in_bus.first_byte),
    .last_byte  (in_bus.last_byte),
    .push       (push)
  );

  // Queue decouples the parser from output stalls.
  bmpdec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back part: one result per cycle into the output register while out_bus is not stalled.
  bmpdec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

[rtl/bmpdec_checker.sv]
// Port-level assertions for the BMP stream pixel decoder and their binding.
`timescale 1ns / 1ps

module bmpdec_checker import bmpdec_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [12:0] out_image_width,
  input logic [12:0] out_image_height,
  input logic [31:0] out_pixel_argb,
  input logic [1:0]  out_error_code,
  input logic        out_last_of_run
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_pixel_argb) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_pixel_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PIXEL) |->
      (out_pixel_argb[31:24] == ALPHA_OPAQUE) && (out_error_code == 2'd0))
    else $error("pixel result not opaque or carries an error code");

  a_dims_header_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_HEADER) |->
      (out_image_width == 13'd0) && (out_image_height == 13'd0))
    else $error("dimensions on a non-header result");

  a_error_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERROR) |-> out_last_of_run)
    else $error("error result is not the last of its byte");

endmodule

bind bmp_stream_pixel_decoder bmpdec_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_kind         (out_bus.kind),
  .out_image_width  (out_bus.image_width),
  .out_image_height (out_bus.image_height),
  .out_pixel_argb   (out_bus.pixel_argb),
  .out_error_code   (out_bus.error_code),
  .out_last_of_run  (out_bus.last_of_run)
);

[tb/tb_bmp_stream_pixel_decoder.sv]
// Self-checking testbench for the BMP stream pixel decoder with a scoreboard class.
`timescale 1ns / 1ps

module tb_bmp_stream_pixel_decoder;
  import bmpdec_pkg::*;

  // One result as it appears on the result channel. Fields that do not apply
  // to a kind are zero.
  typedef struct {
    kind_t       kind;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [31:0] argb;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] index;
    err_t        err;
    logic        last_of_run;
  } bmp_result_t;

  // Header fields that the stimulus places into a generated file.
  typedef struct {
    logic [7:0]  sig0;
    logic [7:0]  sig1;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [31:0] comp;
  } bmp_header_t;

  // The checker keeps its own copy of the parser state. Every accepted byte
  // request is decoded here into the results it must cause, which wait in
  // order until the block delivers them.
  class bmp_decode_checker;
    bmp_result_t pending[$];
    int          mismatches;
    int          checked;
    int          kind_count[4];

    phase_t      phase;
    logic [31:0] byte_pos;
    logic [31:0] data_start;
    logic [7:0]  hdr[HDR_LEN];
    logic [12:0] width;
    logic [12:0] height;
    logic        flip_rows;
    logic        four_byte;
    logic [14:0] row_bytes;
    logic [11:0] col;
    // One bit wider than a row index so that a 4096-row image can finish.
    logic [12:0] row;
    logic [1:0]  pix_phase;
    logic [15:0] bg_hold;

    function new();
      phase      = PH_IDLE;
      byte_pos   = '0;
      data_start = '0;
      width      = '0;
      height     = '0;
      flip_rows  = 1'b0;
      four_byte  = 1'b0;
      row_bytes  = '0;
      col        = '0;
      row        = '0;
      pix_phase  = '0;
      bg_hold    = '0;
      mismatches = 0;
      checked    = 0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function logic [15:0] le16(int off);
      return {hdr[off + 1], hdr[off]};
    endfunction

    function logic [31:0] le32(int off);
      return {le16(off + 2), le16(off)};
    endfunction

    function bmp_result_t fresh(kind_t k);
      bmp_result_t r;
      r.kind         = k;
      r.image_width  = '0;
      r.image_height = '0;
      r.argb         = '0;
      r.x            = '0;
      r.y            = '0;
      r.index        = '0;
      r.err          = ERR_SIG;
      r.last_of_run  = 1'b0;
      return r;
    endfunction

    // Any error ends the file; the parser then waits for the next first byte.
    function bmp_result_t fail_with(err_t e);
      bmp_result_t r;
      r     = fresh(KIND_ERROR);
      r.err = e;
      phase = PH_DONE;
      return r;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    // Decode one accepted byte and queue what it should produce.
    function void take_byte(logic [7:0] b, logic is_first, logic is_last);
      bmp_result_t run[$];
      bmp_result_t r;
      logic [31:0] w, h, hmag;
      logic [15:0] bpp;
      int unsigned bpp_bytes, data_bytes, row_span, y_row;
      logic        pix, done;
      logic [23:0] rgb;
      logic [11:0] px;

      pix = 1'b0;
      done = 1'b0;
      rgb = '0;
      px = '0;
      if (is_first) begin
        phase    = PH_HEADER;
        byte_pos = '0;
      end

      case (phase)
        PH_HEADER: begin
          hdr[byte_pos] = b;
          if (byte_pos < HDR_LEN - 1) begin
            byte_pos++;
            if (is_last) run.insert(run.size(), fail_with(ERR_TRUNC));
          end else begin
            // All 54 header bytes are in: validate and latch the geometry.
            w    = le32(OFF_WIDTH);
            h    = le32(OFF_HEIGHT);
            bpp  = le16(OFF_BPP);
            hmag = h[31] ? -h : h;
            if (hdr[0] != SIG_B || hdr[1] != SIG_M) begin
              run.insert(run.size(), fail_with(ERR_SIG));
            end else if (le32(OFF_COMP) != 0 || (bpp != BPP_24 && bpp != BPP_32) ||
                         w[31] || w > MAX_DIM || hmag > MAX_DIM ||
                         le32(OFF_DATA) < HDR_LEN) begin
              run.insert(run.size(), fail_with(ERR_FMT));
            end else begin
              data_start = le32(OFF_DATA);
              width      = w[12:0];
              height     = hmag[12:0];
              flip_rows  = !h[31] && h != 0;
              four_byte  = (bpp == BPP_32);
              row_bytes  = '0;
              col        = '0;
              row        = '0;
              pix_phase  = '0;
              bg_hold    = '0;
              byte_pos   = HDR_LEN;
              r = fresh(KIND_HEADER);
              r.image_width  = width;
              r.image_height = height;
              run.insert(run.size(), r);
              if (width == 0 || height == 0) begin
                run.insert(run.size(), fresh(KIND_DONE));
                phase = PH_DONE;
              end else begin
                phase = (data_start == HDR_LEN) ? PH_PIXELS : PH_SKIP;
                if (is_last) run.insert(run.size(), fail_with(ERR_TRUNC));
              end
            end
          end
        end
        PH_SKIP: begin
          if (byte_pos == data_start - 1) phase = PH_PIXELS;
          byte_pos++;
          if (is_last) run.insert(run.size(), fail_with(ERR_TRUNC));
        end
        PH_PIXELS: begin
          bpp_bytes  = four_byte ? 4 : 3;
          data_bytes = width * bpp_bytes;
          row_span   = ((data_bytes + 3) / 4) * 4;
          // Pixel bytes arrive blue, green, red (then alpha, which is dropped).
          if (row_bytes < data_bytes) begin
            case (pix_phase)
              2'd0: bg_hold = {8'h00, b};
              2'd1: bg_hold = {b, bg_hold[7:0]};
              2'd2: begin
                rgb = {b, bg_hold};
                px  = col;
                pix = 1'b1;
                col++;
              end
              default: ;
            endcase
            if (pix_phase + 1 >= bpp_bytes) pix_phase = '0;
            else pix_phase++;
          end
          y_row = flip_rows ? height - 1 - row : row;
          if (row_bytes + 1 >= row_span) begin
            row_bytes = '0;
            col       = '0;
            pix_phase = '0;
            row++;
            done = (row >= height);
          end else begin
            row_bytes++;
          end
          // A pixel finished on a truncating byte is dropped, unless that byte
          // also finished the image.
          if (pix && (done || !is_last)) begin
            r = fresh(KIND_PIXEL);
            r.argb  = {ALPHA_OPAQUE, rgb};
            r.x     = px;
            r.y     = y_row[11:0];
            r.index = 24'(y_row * width + px);
            run.insert(run.size(), r);
          end
          if (done) begin
            run.insert(run.size(), fresh(KIND_DONE));
            phase = PH_DONE;
          end else if (is_last) begin
            run.insert(run.size(), fail_with(ERR_TRUNC));
          end
        end
        default: ;
      endcase

      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pending.insert(pending.size(), run[i]);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h", checked, name, got, want));
    endtask

    task check_result(bmp_result_t got);
      bmp_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result of kind %0d arrived with nothing expected", got.kind));
        return;
      end
      want = pending.pop_front();
      checked++;
      kind_count[want.kind]++;
      compare("kind", got.kind, want.kind);
      compare("image_width", got.image_width, want.image_width);
      compare("image_height", got.image_height, want.image_height);
      compare("pixel_argb", got.argb, want.argb);
      compare("pixel_x", got.x, want.x);
      compare("pixel_y", got.y, want.y);
      compare("pixel_index", got.index, want.index);
      compare("error_code", got.err, want.err);
      compare("last_of_run", got.last_of_run, want.last_of_run);
    endtask
  endclass

  logic clk;
  logic rst_n;

  bmpdec_in_if  in_ch();
  bmpdec_out_if out_ch();

  bmp_stream_pixel_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  bmp_decode_checker sb;
  bmp_result_t       seen;

  // Gap modes per file: 0 means back-to-back requests, anything else draws a
  // random wait, which may be zero, before every request on that side.
  int src_mode;
  int sink_mode;

  int files_sent;
  int bytes_sent;
  logic [7:0] file_bytes[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(int mode);
    return (mode == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  // Both channels are observed at the rising edge. Input requests are decoded
  // before results are checked, so a result is never compared against a
  // prediction made later in the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.take_byte(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen.kind         = kind_t'(out_ch.kind);
        seen.image_width  = out_ch.image_width;
        seen.image_height = out_ch.image_height;
        seen.argb         = out_ch.pixel_argb;
        seen.x            = out_ch.pixel_x;
        seen.y            = out_ch.pixel_y;
        seen.index        = out_ch.pixel_index;
        seen.err          = err_t'(out_ch.error_code);
        seen.last_of_run  = out_ch.last_of_run;
        sb.check_result(seen);
      end
    end
  end

  // Result side: before each result request the receiver may hold ready low
  // for a random number of cycles. A zero wait leaves ready high, so ready is
  // never dropped and raised in the same time step.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      @(negedge clk);
      gap = draw_gap(sink_mode);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Drive one byte request and return at the edge where it is taken.
  task send_byte(logic [7:0] b, logic is_first, logic is_last);
    int gap;
    gap = draw_gap(src_mode);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= is_first;
    in_ch.last_byte  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  function automatic bmp_header_t good_header(logic [31:0] w, logic [31:0] h,
                                              logic [15:0] bpp, logic [31:0] offs);
    bmp_header_t hh;
    hh.sig0   = SIG_B;
    hh.sig1   = SIG_M;
    hh.offset = offs;
    hh.width  = w;
    hh.height = h;
    hh.bpp    = bpp;
    hh.comp   = '0;
    return hh;
  endfunction

  // Length of a well-formed file up to and including its final image byte.
  function automatic int image_len(bmp_header_t hh);
    longint hmag, row_span;
    hmag     = hh.height[31] ? longint'(-hh.height) : longint'(hh.height);
    row_span = ((longint'(hh.width) * ((hh.bpp == BPP_32) ? 4 : 3) + 3) / 4) * 4;
    return int'(longint'(hh.offset) + hmag * row_span);
  endfunction

  function automatic void put32(int off, logic [31:0] v);
    for (int k = 0; k < 4; k++) file_bytes[off + k] = v[8 * k +: 8];
  endfunction

  // Random bytes with the header fields laid over them, cut to total bytes.
  function automatic void build_file(bmp_header_t hh, int total);
    file_bytes.delete();
    for (int i = 0; i < ((total < HDR_LEN) ? HDR_LEN : total); i++)
      file_bytes.insert(file_bytes.size(), 8'($urandom_range(0, 255)));
    file_bytes[0] = hh.sig0;
    file_bytes[1] = hh.sig1;
    put32(OFF_DATA, hh.offset);
    put32(OFF_WIDTH, hh.width);
    put32(OFF_HEIGHT, hh.height);
    file_bytes[OFF_BPP]     = hh.bpp[7:0];
    file_bytes[OFF_BPP + 1] = hh.bpp[15:8];
    put32(OFF_COMP, hh.comp);
    while (file_bytes.size() > total) void'(file_bytes.pop_back());
  endfunction

  // Stream a file; last_byte is set on byte last_at (none when negative).
  task run_file(bmp_header_t hh, int total, int last_at);
    build_file(hh, total);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0, i == last_at);
    files_sent++;
  endtask

  // Bytes outside any file; the parser must ignore them.
  task send_noise(int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  function automatic bmp_header_t random_header();
    int w, hm;
    logic [31:0] offs;
    if ($urandom_range(0, 19) == 0) begin
      w  = $urandom_range(6, 40);
      hm = 1;
    end else begin
      w  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
      hm = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
    end
    offs = HDR_LEN + (($urandom_range(0, 4) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 5));
    return good_header(w, $urandom_range(0, 1) ? hm : -hm,
                       $urandom_range(0, 1) ? BPP_24 : BPP_32, offs);
  endfunction

  // Break exactly one header rule.
  function automatic bmp_header_t corrupt_header(bmp_header_t hh);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: do hh.sig0 = 8'($urandom_range(0, 255)); while (hh.sig0 == SIG_B);
      1: do hh.sig1 = 8'($urandom_range(0, 255)); while (hh.sig1 == SIG_M);
      2: do hh.comp = $urandom(); while (hh.comp == 0);
      3: do hh.bpp = 16'($urandom()); while (hh.bpp == BPP_24 || hh.bpp == BPP_32);
      4: hh.width = $urandom() | 32'h8000_0000;
      5: hh.width = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
      6: begin
        v = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
        hh.height = $urandom_range(0, 1) ? v : -v;
      end
      default: hh.offset = $urandom_range(0, HDR_LEN - 1);
    endcase
    return hh;
  endfunction

  initial begin
    bmp_header_t hh;
    int len, cat, t, extra;

    sb = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    src_mode         = 1;
    sink_mode        = 1;
    files_sent       = 0;
    bytes_sent       = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed files. Bytes before any first byte are ignored by the parser.
    send_noise(3);
    // Bad signature with last on the 54th byte: the signature error wins.
    hh = good_header(2, 2, BPP_24, HDR_LEN);
    hh.sig1 = 8'hFF;
    run_file(hh, HDR_LEN, HDR_LEN - 1);
    // Rejections right at the size limits and the smallest offset.
    run_file(good_header(MAX_DIM + 1, 2, BPP_24, HDR_LEN), HDR_LEN, -1);
    run_file(good_header(2, -(MAX_DIM + 1), BPP_32, HDR_LEN), HDR_LEN, -1);
    run_file(good_header(2, 2, BPP_24, HDR_LEN - 1), HDR_LEN + 4, -1);
    // Empty image at the width limit: header and complete together.
    run_file(good_header(MAX_DIM, 0, BPP_24, HDR_LEN), 60, 59);
    // Truncation on the very first byte, and on the 54th byte.
    run_file(good_header(2, 2, BPP_24, HDR_LEN), 1, 0);
    run_file(good_header(MAX_DIM, -MAX_DIM, BPP_24, HDR_LEN), HDR_LEN, HDR_LEN - 1);
    // Truncation in a huge skip area.
    run_file(good_header(2, 2, BPP_24, 32'hFFFF_FFFF), 70, 69);
    // Truncation on the byte that completes a pixel, and on an alpha byte.
    run_file(good_header(2, 2, BPP_24, HDR_LEN), 57, 56);
    run_file(good_header(2, 2, BPP_32, HDR_LEN), 58, 57);
    // Largest geometry: the first row of a bottom-up 4096 by 4096 image lands
    // on the last destination row; the stream ends after four pixels.
    src_mode = 0;
    hh = good_header(MAX_DIM, MAX_DIM, BPP_24, HDR_LEN);
    run_file(hh, HDR_LEN + 3 * 4 + 1, HDR_LEN + 3 * 4);

    // Random files, mostly well formed so the pixel path is exercised.
    while (bytes_sent < 950) begin
      src_mode  = $urandom_range(0, 3);
      sink_mode = $urandom_range(0, 3);
      hh  = random_header();
      len = image_len(hh);
      cat = $urandom_range(0, 99);
      if (cat < 60) begin
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        case ($urandom_range(0, 2))
          0: run_file(hh, len + extra, -1);
          1: run_file(hh, len + extra, len - 1);
          default: run_file(hh, len + extra, len + extra - 1);
        endcase
      end else if (cat < 78) begin
        t = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1)
                                        : $urandom_range(HDR_LEN, len - 1);
        run_file(hh, t, t - 1);
      end else if (cat < 90) begin
        t = HDR_LEN + $urandom_range(0, 6);
        run_file(corrupt_header(hh), t, $urandom_range(0, 1) ? t - 1 : -1);
      end else begin
        // Partial file; the next first byte restarts the parser.
        t = $urandom_range(1, len - 1);
        run_file(hh, t, -1);
      end
      if (cat < 90 && $urandom_range(0, 5) == 0) send_noise($urandom_range(1, 3));
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d files in %0d byte requests, %0d results checked",
             files_sent, bytes_sent, sb.checked);
    $display("summary: %0d headers, %0d pixels, %0d complete, %0d errors, %0d mismatches",
             sb.kind_count[KIND_HEADER], sb.kind_count[KIND_PIXEL],
             sb.kind_count[KIND_DONE], sb.kind_count[KIND_ERROR], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
